// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the pair energy core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LJPE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ljpe assertion failed");
// Boolean condition must never be seen outside reset.
`define LJPE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ljpe forbidden condition seen");
`else
`define LJPE_ASSERT(lbl, clk, rst_n, prop)
`define LJPE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/ljpe_pkg.sv -----
// Shared constants, types and arithmetic helpers of the pair energy core.
`timescale 1ns / 1ps
package ljpe_pkg;

	localparam int NUM_SPECIES = 16;
	localparam int FRAC_BITS   = 20;
	localparam int SPECIES_W   = 4;
	localparam int TABLE_DEPTH = NUM_SPECIES * NUM_SPECIES;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int COORD_W   = 32;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int RS_W      = SQ_W + 2;
	localparam int Q_W       = 64;
	localparam int DIV_STEPS = Q_W;
	localparam int LANES     = 2;
	localparam int LANE_U    = 0;
	localparam int LANE_V    = 1;
	localparam int MAG_W     = Q_W + 1;
	localparam int PH_W      = MAG_W;
	localparam int PROD_W    = MAG_W + COORD_W;
	localparam int E_SHIFT   = FRAC_BITS - 2;
	localparam int ENERGY_W  = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	localparam logic [COORD_W-1:0]  BOX_RESET      = 32'h4000_0000;
	localparam logic [ENERGY_W-1:0] ENERGY_POS_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic [ENERGY_W-1:0] ENERGY_NEG_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	typedef struct packed {
		logic [COORD_W-1:0] epsilon;
		logic [COORD_W-1:0] sigma;
		logic [COORD_W-1:0] cutoff;
	} coef_t;

	typedef struct packed {
		logic in_cut;
		logic force_max;
	} flags_t;

	typedef struct packed {
		logic [Q_W-1:0] p00;
		logic [Q_W-1:0] p01;
		logic [Q_W-1:0] p10;
		logic [Q_W-1:0] p11;
	} qpart_t;

	typedef struct packed {
		logic [Q_W-1:0] val;
		logic           ovf;
	} qres_t;

	typedef struct packed {
		logic [RS_W-1:0] rem;
		logic            q;
	} dstep_t;

	// Four 32x32 partial products of a Q32.32 multiply.
	function automatic qpart_t qmul_split(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
		qpart_t p;
		p.p00 = Q_W'(a[31:0])  * Q_W'(b[31:0]);
		p.p01 = Q_W'(a[31:0])  * Q_W'(b[63:32]);
		p.p10 = Q_W'(a[63:32]) * Q_W'(b[31:0]);
		p.p11 = Q_W'(a[63:32]) * Q_W'(b[63:32]);
		return p;
	endfunction

	// Sum the partial products, drop 32 fraction bits, flag overflow.
	function automatic qres_t qmul_join(input qpart_t p);
		logic [2*Q_W-1:0] sum;
		qres_t r;
		sum = {64'b0, p.p00} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
			+ {p.p11, 64'b0};
		r.val = sum[95:32];
		r.ovf = |sum[127:96];
		return r;
	endfunction

	// One restoring division step: shift in a numerator bit, try subtract.
	function automatic dstep_t div_step(input logic [RS_W-1:0] rem, input logic nbit,
			input logic [RS_W-1:0] den);
		logic [RS_W:0] t;
		logic [RS_W:0] diff;
		dstep_t r;
		t     = {rem, nbit};
		diff  = t - {1'b0, den};
		r.q   = (t >= {1'b0, den});
		r.rem = r.q ? diff[RS_W-1:0] : t[RS_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/ljpe_front.sv -----
// Front stages: coefficient table, minimum-image distance, squares and cutoff test.
`timescale 1ns / 1ps
module ljpe_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                accept,
	input  logic                                operation,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_x,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_y,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_z,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_x,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_y,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_z,
	input  logic [ljpe_pkg::SPECIES_W-1:0]      species_a,
	input  logic [ljpe_pkg::SPECIES_W-1:0]      species_b,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_epsilon,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_sigma,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_cutoff,
	input  logic [ljpe_pkg::COORD_W-1:0]        box_x,
	input  logic [ljpe_pkg::COORD_W-1:0]        box_y,
	input  logic [ljpe_pkg::COORD_W-1:0]        box_z,
	output logic                                valid,
	output ljpe_pkg::flags_t                    flags,
	output logic [ljpe_pkg::COORD_W-1:0]        eps,
	output logic [ljpe_pkg::SQ_W-1:0]           s2,
	output logic [ljpe_pkg::RS_W-1:0]           rs,
	output logic [ljpe_pkg::SQ_W-1:0]           rcs
);

	localparam int CW = ljpe_pkg::COORD_W;

	ljpe_pkg::coef_t                table_mem [ljpe_pkg::TABLE_DEPTH];
	logic                           ok;
	logic [ljpe_pkg::IDX_W-1:0]     idx;
	logic [CW-1:0]                  pa [3];
	logic [CW-1:0]                  pb [3];
	logic [CW-1:0]                  box [3];
	logic [CW-1:0]                  fold [3];

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                           cmp_s1, cmp_s2, cmp_s3, cmp_s4;
	ljpe_pkg::coef_t                coef_s1, coef_s2;
	logic [CW-1:0]                  dabs_s1 [3];
	logic [CW-1:0]                  d_s2 [3];
	logic [ljpe_pkg::SQ_W-1:0]      sq_s3 [3];
	logic [ljpe_pkg::SQ_W-1:0]      s2_s3, rcs_s3, s2_s4, rcs_s4, s2_s5, rcs_s5;
	logic [CW-1:0]                  eps_s3, eps_s4, eps_s5;
	logic [ljpe_pkg::RS_W-1:0]      rs_s4, rs_s5;
	ljpe_pkg::flags_t               flags_s5;

	// Table address and species range check.
	always_comb begin
		ok  = (int'(species_a) < ljpe_pkg::NUM_SPECIES)
			&& (int'(species_b) < ljpe_pkg::NUM_SPECIES);
		idx = ljpe_pkg::IDX_W'(int'(species_a) * ljpe_pkg::NUM_SPECIES + int'(species_b));
		pa[0] = pos_a_x; pa[1] = pos_a_y; pa[2] = pos_a_z;
		pb[0] = pos_b_x; pb[1] = pos_b_y; pb[2] = pos_b_z;
		box[0] = box_x; box[1] = box_y; box[2] = box_z;
	end

	// Write on a load beat, read on every advance.
	always_ff @(posedge clk) begin
		if (accept && operation == ljpe_pkg::OP_LOAD && ok) begin
			table_mem[idx] <= '{epsilon: load_epsilon, sigma: load_sigma,
				cutoff: load_cutoff};
		end
		if (en) begin
			coef_s1 <= table_mem[idx];
		end
	end

	// Fold each axis distance into the nearest image.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if ({dabs_s1[i], 1'b0} > {1'b0, box[i]}) begin
				fold[i] = (dabs_s1[i] > box[i]) ? dabs_s1[i] - box[i] : box[i] - dabs_s1[i];
			end else begin
				fold[i] = dabs_s1[i];
			end
		end
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance payload.
	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s1 <= (operation == ljpe_pkg::OP_COMPUTE) && ok;
			for (int i = 0; i < 3; i++) begin
				dabs_s1[i] <= (pa[i] > pb[i]) ? pa[i] - pb[i] : pb[i] - pa[i];
				d_s2[i]    <= fold[i];
				sq_s3[i]   <= ljpe_pkg::SQ_W'(d_s2[i]) * ljpe_pkg::SQ_W'(d_s2[i]);
			end
			cmp_s2  <= cmp_s1;
			coef_s2 <= coef_s1;
			cmp_s3  <= cmp_s2;
			eps_s3  <= coef_s2.epsilon;
			s2_s3   <= ljpe_pkg::SQ_W'(coef_s2.sigma) * ljpe_pkg::SQ_W'(coef_s2.sigma);
			rcs_s3  <= ljpe_pkg::SQ_W'(coef_s2.cutoff) * ljpe_pkg::SQ_W'(coef_s2.cutoff);
			cmp_s4  <= cmp_s3;
			eps_s4  <= eps_s3;
			s2_s4   <= s2_s3;
			rcs_s4  <= rcs_s3;
			rs_s4   <= ljpe_pkg::RS_W'(sq_s3[0]) + ljpe_pkg::RS_W'(sq_s3[1])
				+ ljpe_pkg::RS_W'(sq_s3[2]);
			// Cutoff test, zero distance and ratio overflow checks.
			flags_s5.in_cut    <= cmp_s4 && (rs_s4 < ljpe_pkg::RS_W'(rcs_s4));
			flags_s5.force_max <= (rs_s4 == '0)
				|| ((rs_s4[ljpe_pkg::RS_W-1:32] == '0) && (s2_s4[63:32] >= rs_s4[31:0]))
				|| ((rcs_s4[63:32] == '0) && (s2_s4[63:32] >= rcs_s4[31:0]));
			eps_s5 <= eps_s4;
			s2_s5  <= s2_s4;
			rcs_s5 <= rcs_s4;
			rs_s5  <= rs_s4;
		end
	end

	assign valid = v_s5;
	assign flags = flags_s5;
	assign eps   = eps_s5;
	assign s2    = s2_s5;
	assign rs    = rs_s5;
	assign rcs   = rcs_s5;

endmodule

// ----- rtl/core/ljpe_div.sv -----
// Pipelined restoring divider: sigma^2/r^2 and sigma^2/rc^2, one quotient bit per stage.
`timescale 1ns / 1ps
module ljpe_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid_in,
	input  ljpe_pkg::flags_t                flags_in,
	input  logic [ljpe_pkg::COORD_W-1:0]    eps_in,
	input  logic [ljpe_pkg::SQ_W-1:0]       s2,
	input  logic [ljpe_pkg::RS_W-1:0]       rs,
	input  logic [ljpe_pkg::SQ_W-1:0]       rcs,
	output logic                            valid,
	output ljpe_pkg::flags_t                flags,
	output logic [ljpe_pkg::COORD_W-1:0]    eps,
	output logic [ljpe_pkg::Q_W-1:0]        quo_u,
	output logic [ljpe_pkg::Q_W-1:0]        quo_v
);

	localparam int N  = ljpe_pkg::DIV_STEPS;
	localparam int L  = ljpe_pkg::LANES;
	localparam int RW = ljpe_pkg::RS_W;
	localparam int QW = ljpe_pkg::Q_W;

	logic                           v_in   [N];
	ljpe_pkg::flags_t               flg_in [N];
	logic [ljpe_pkg::COORD_W-1:0]   eps_i  [N];
	logic [QW-1:0]                  nb_in  [N];
	logic [RW-1:0]                  den_in [N][L];
	logic [RW-1:0]                  rem_in [N][L];
	logic [QW-1:0]                  quo_in [N][L];
	ljpe_pkg::dstep_t               st     [N][L];

	logic                           v_s   [N];
	ljpe_pkg::flags_t               flg_s [N];
	logic [ljpe_pkg::COORD_W-1:0]   eps_s [N];
	logic [QW-1:0]                  nb_s  [N];
	logic [RW-1:0]                  den_s [N][L];
	logic [RW-1:0]                  rem_s [N][L];
	logic [QW-1:0]                  quo_s [N][L];

	// Stage inputs and one division step per lane.
	always_comb begin
		v_in[0]   = valid_in;
		flg_in[0] = flags_in;
		eps_i[0]  = eps_in;
		nb_in[0]  = {s2[31:0], 32'b0};
		den_in[0][ljpe_pkg::LANE_U] = rs;
		den_in[0][ljpe_pkg::LANE_V] = RW'(rcs);
		for (int l = 0; l < L; l++) begin
			rem_in[0][l] = RW'(s2[63:32]);
			quo_in[0][l] = '0;
		end
		for (int k = 1; k < N; k++) begin
			v_in[k]   = v_s[k-1];
			flg_in[k] = flg_s[k-1];
			eps_i[k]  = eps_s[k-1];
			nb_in[k]  = nb_s[k-1];
			for (int l = 0; l < L; l++) begin
				den_in[k][l] = den_s[k-1][l];
				rem_in[k][l] = rem_s[k-1][l];
				quo_in[k][l] = quo_s[k-1][l];
			end
		end
		for (int k = 0; k < N; k++) begin
			for (int l = 0; l < L; l++) begin
				st[k][l] = ljpe_pkg::div_step(rem_in[k][l], nb_in[k][QW-1], den_in[k][l]);
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		// Advance valid bit.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in[k];
			end
		end

		// Advance remainder, quotient and carried payload.
		always_ff @(posedge clk) begin
			if (en) begin
				flg_s[k] <= flg_in[k];
				eps_s[k] <= eps_i[k];
				nb_s[k]  <= {nb_in[k][QW-2:0], 1'b0};
				for (int l = 0; l < L; l++) begin
					den_s[k][l] <= den_in[k][l];
					rem_s[k][l] <= st[k][l].rem;
					quo_s[k][l] <= {quo_in[k][l][QW-2:0], st[k][l].q};
				end
			end
		end
	end

	assign valid = v_s[N-1];
	assign flags = flg_s[N-1];
	assign eps   = eps_s[N-1];
	assign quo_u = quo_s[N-1][ljpe_pkg::LANE_U];
	assign quo_v = quo_s[N-1][ljpe_pkg::LANE_V];

endmodule

// ----- rtl/core/ljpe_pow.sv -----
// Power stages: x^2, x^3 and x^6 of both ratios in Q32.32 with overflow tracking.
`timescale 1ns / 1ps
module ljpe_pow (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid_in,
	input  ljpe_pkg::flags_t                flags_in,
	input  logic [ljpe_pkg::COORD_W-1:0]    eps_in,
	input  logic [ljpe_pkg::Q_W-1:0]        u,
	input  logic [ljpe_pkg::Q_W-1:0]        v,
	output logic                            valid,
	output ljpe_pkg::flags_t                flags,
	output logic [ljpe_pkg::COORD_W-1:0]    eps,
	output logic [ljpe_pkg::Q_W-1:0]        u3,
	output logic [ljpe_pkg::Q_W-1:0]        u6,
	output logic [ljpe_pkg::Q_W-1:0]        v3,
	output logic [ljpe_pkg::Q_W-1:0]        v6
);

	localparam int L  = ljpe_pkg::LANES;
	localparam int QW = ljpe_pkg::Q_W;

	logic [QW-1:0]                  x [L];
	ljpe_pkg::qres_t                j2 [L];
	ljpe_pkg::qres_t                j4 [L];
	ljpe_pkg::qres_t                j6 [L];

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ljpe_pkg::flags_t               f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [ljpe_pkg::COORD_W-1:0]   e_s1, e_s2, e_s3, e_s4, e_s5, e_s6;
	ljpe_pkg::qpart_t               part_s1 [L];
	ljpe_pkg::qpart_t               part_s3 [L];
	ljpe_pkg::qpart_t               part_s5 [L];
	logic [QW-1:0]                  x_s1 [L];
	logic [QW-1:0]                  x_s2 [L];
	logic [QW-1:0]                  x2_s2 [L];
	logic [QW-1:0]                  x3_s4 [L];
	logic [QW-1:0]                  x3_s5 [L];
	logic [QW-1:0]                  x3_s6 [L];
	logic [QW-1:0]                  x6_s6 [L];

	// Combine partial products of each multiply.
	always_comb begin
		x[ljpe_pkg::LANE_U] = u;
		x[ljpe_pkg::LANE_V] = v;
		for (int l = 0; l < L; l++) begin
			j2[l] = ljpe_pkg::qmul_join(part_s1[l]);
			j4[l] = ljpe_pkg::qmul_join(part_s3[l]);
			j6[l] = ljpe_pkg::qmul_join(part_s5[l]);
		end
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Multiply split and join stages; overflow forces the rail.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= flags_in;
			e_s1 <= eps_in;
			f_s2 <= '{in_cut: f_s1.in_cut,
				force_max: f_s1.force_max || j2[0].ovf || j2[1].ovf};
			e_s2 <= e_s1;
			f_s3 <= f_s2;
			e_s3 <= e_s2;
			f_s4 <= '{in_cut: f_s3.in_cut,
				force_max: f_s3.force_max || j4[0].ovf || j4[1].ovf};
			e_s4 <= e_s3;
			f_s5 <= f_s4;
			e_s5 <= e_s4;
			f_s6 <= '{in_cut: f_s5.in_cut,
				force_max: f_s5.force_max || j6[0].ovf || j6[1].ovf};
			e_s6 <= e_s5;
			for (int l = 0; l < L; l++) begin
				part_s1[l] <= ljpe_pkg::qmul_split(x[l], x[l]);
				x_s1[l]    <= x[l];
				x2_s2[l]   <= j2[l].val;
				x_s2[l]    <= x_s1[l];
				part_s3[l] <= ljpe_pkg::qmul_split(x2_s2[l], x_s2[l]);
				x3_s4[l]   <= j4[l].val;
				part_s5[l] <= ljpe_pkg::qmul_split(x3_s4[l], x3_s4[l]);
				x3_s5[l]   <= x3_s4[l];
				x6_s6[l]   <= j6[l].val;
				x3_s6[l]   <= x3_s5[l];
			end
		end
	end

	assign valid = v_s6;
	assign flags = f_s6;
	assign eps   = e_s6;
	assign u3    = x3_s6[ljpe_pkg::LANE_U];
	assign u6    = x6_s6[ljpe_pkg::LANE_U];
	assign v3    = x3_s6[ljpe_pkg::LANE_V];
	assign v6    = x6_s6[ljpe_pkg::LANE_V];

endmodule

// ----- rtl/core/ljpe_energy.sv -----
// Energy stages: bracket, epsilon scaling, saturation and the output register.
`timescale 1ns / 1ps
module ljpe_energy (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_in,
	input  ljpe_pkg::flags_t                    flags_in,
	input  logic [ljpe_pkg::COORD_W-1:0]        eps_in,
	input  logic [ljpe_pkg::Q_W-1:0]            u3,
	input  logic [ljpe_pkg::Q_W-1:0]            u6,
	input  logic [ljpe_pkg::Q_W-1:0]            v3,
	input  logic [ljpe_pkg::Q_W-1:0]            v6,
	output logic                                valid,
	output logic signed [ljpe_pkg::ENERGY_W-1:0] energy,
	output logic                                inside_cutoff,
	output logic                                saturated
);

	localparam int MW = ljpe_pkg::MAG_W;
	localparam int PW = ljpe_pkg::PROD_W;
	localparam int EW = ljpe_pkg::ENERGY_W;

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5;
	ljpe_pkg::flags_t               f_s1, f_s2, f_s3, f_s4;
	logic [ljpe_pkg::COORD_W-1:0]   e_s1, e_s2;
	logic [MW-1:0]                  pos_s1, neg_s1, mag_s2;
	logic                           negv_s2, negv_s3, negv_s4;
	logic [2*ljpe_pkg::COORD_W-1:0] pl_s3;
	logic [ljpe_pkg::PH_W-1:0]      ph_s3;
	logic [PW-1:0]                  prod_s4;
	logic [PW-1:0]                  sh;
	logic                           pos_ovf, neg_ovf;
	logic [EW-1:0]                  energy_s5;
	logic                           inside_s5, sat_s5;

	// Scale by four and drop fraction bits, then clip to the rails.
	always_comb begin
		sh      = prod_s4 >> ljpe_pkg::E_SHIFT;
		pos_ovf = |sh[PW-1:EW-1];
		neg_ovf = (|sh[PW-1:EW]) || (sh[EW-1] && (|sh[EW-2:0]));
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance payload; hold the output register while stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= flags_in;
			e_s1   <= eps_in;
			pos_s1 <= MW'(u6) + MW'(v3);
			neg_s1 <= MW'(u3) + MW'(v6);
			f_s2    <= f_s1;
			e_s2    <= e_s1;
			negv_s2 <= pos_s1 < neg_s1;
			mag_s2  <= (pos_s1 < neg_s1) ? neg_s1 - pos_s1 : pos_s1 - neg_s1;
			f_s3    <= f_s2;
			negv_s3 <= negv_s2;
			pl_s3   <= (2*ljpe_pkg::COORD_W)'(mag_s2[31:0]) * (2*ljpe_pkg::COORD_W)'(e_s2);
			ph_s3   <= ljpe_pkg::PH_W'(mag_s2[MW-1:32]) * ljpe_pkg::PH_W'(e_s2);
			f_s4    <= f_s3;
			negv_s4 <= negv_s3;
			prod_s4 <= PW'({ph_s3, 32'b0}) + PW'(pl_s3);
			inside_s5 <= f_s4.in_cut;
			if (!f_s4.in_cut) begin
				energy_s5 <= '0;
				sat_s5    <= 1'b0;
			end else if (f_s4.force_max) begin
				energy_s5 <= ljpe_pkg::ENERGY_POS_MAX;
				sat_s5    <= 1'b1;
			end else if (!negv_s4) begin
				energy_s5 <= pos_ovf ? ljpe_pkg::ENERGY_POS_MAX : sh[EW-1:0];
				sat_s5    <= pos_ovf;
			end else begin
				energy_s5 <= neg_ovf ? ljpe_pkg::ENERGY_NEG_MIN : (~sh[EW-1:0]) + 1'b1;
				sat_s5    <= neg_ovf;
			end
		end
	end

	assign valid         = v_s5;
	assign energy        = energy_s5;
	assign inside_cutoff = inside_s5;
	assign saturated     = sat_s5;

endmodule

// ----- rtl/core/lj_pair_energy_min_image_core.sv -----
// An accepted beat passes the front, divider, power and energy stages to its result on the output register.
// Throughput: one beat per cycle; the 64-stage divider, one quotient bit per stage, sets depth.
// The whole pipeline freezes while a result is held on a stalled output.
// Reset clears all valid bits and sets the box lengths to 1024.0; the coefficient
// table is not cleared and holds unknown data until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lj_pair_energy_min_image_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_x,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_y,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_a_z,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_x,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_y,
	input  logic [ljpe_pkg::COORD_W-1:0]        pos_b_z,
	input  logic [ljpe_pkg::SPECIES_W-1:0]      species_a,
	input  logic [ljpe_pkg::SPECIES_W-1:0]      species_b,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_epsilon,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_sigma,
	input  logic [ljpe_pkg::COORD_W-1:0]        load_cutoff,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ljpe_pkg::ENERGY_W-1:0] energy,
	output logic                                inside_cutoff,
	output logic                                saturated,
	input  logic                                cfg_we,
	input  logic [ljpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ljpe_pkg::COORD_W-1:0]        cfg_wdata
);

	logic                           en;
	logic                           accept;
	logic [ljpe_pkg::COORD_W-1:0]   box_x_q, box_y_q, box_z_q;

	logic                           fr_valid;
	ljpe_pkg::flags_t               fr_flags;
	logic [ljpe_pkg::COORD_W-1:0]   fr_eps;
	logic [ljpe_pkg::SQ_W-1:0]      fr_s2;
	logic [ljpe_pkg::RS_W-1:0]      fr_rs;
	logic [ljpe_pkg::SQ_W-1:0]      fr_rcs;

	logic                           dv_valid;
	ljpe_pkg::flags_t               dv_flags;
	logic [ljpe_pkg::COORD_W-1:0]   dv_eps;
	logic [ljpe_pkg::Q_W-1:0]       dv_u, dv_v;

	logic                           pw_valid;
	ljpe_pkg::flags_t               pw_flags;
	logic [ljpe_pkg::COORD_W-1:0]   pw_eps;
	logic [ljpe_pkg::Q_W-1:0]       pw_u3, pw_u6, pw_v3, pw_v6;

	// Advance everything unless a result waits on a stalled output.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// Box length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= ljpe_pkg::BOX_RESET;
			box_y_q <= ljpe_pkg::BOX_RESET;
			box_z_q <= ljpe_pkg::BOX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ljpe_pkg::CFG_BOX_X: box_x_q <= cfg_wdata;
				ljpe_pkg::CFG_BOX_Y: box_y_q <= cfg_wdata;
				ljpe_pkg::CFG_BOX_Z: box_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ljpe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.accept       (accept),
		.operation    (operation),
		.pos_a_x      (pos_a_x),
		.pos_a_y      (pos_a_y),
		.pos_a_z      (pos_a_z),
		.pos_b_x      (pos_b_x),
		.pos_b_y      (pos_b_y),
		.pos_b_z      (pos_b_z),
		.species_a    (species_a),
		.species_b    (species_b),
		.load_epsilon (load_epsilon),
		.load_sigma   (load_sigma),
		.load_cutoff  (load_cutoff),
		.box_x        (box_x_q),
		.box_y        (box_y_q),
		.box_z        (box_z_q),
		.valid        (fr_valid),
		.flags        (fr_flags),
		.eps          (fr_eps),
		.s2           (fr_s2),
		.rs           (fr_rs),
		.rcs          (fr_rcs)
	);

	ljpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (fr_valid),
		.flags_in (fr_flags),
		.eps_in   (fr_eps),
		.s2       (fr_s2),
		.rs       (fr_rs),
		.rcs      (fr_rcs),
		.valid    (dv_valid),
		.flags    (dv_flags),
		.eps      (dv_eps),
		.quo_u    (dv_u),
		.quo_v    (dv_v)
	);

	ljpe_pow u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (dv_valid),
		.flags_in (dv_flags),
		.eps_in   (dv_eps),
		.u        (dv_u),
		.v        (dv_v),
		.valid    (pw_valid),
		.flags    (pw_flags),
		.eps      (pw_eps),
		.u3       (pw_u3),
		.u6       (pw_u6),
		.v3       (pw_v3),
		.v6       (pw_v6)
	);

	ljpe_energy u_energy (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.valid_in      (pw_valid),
		.flags_in      (pw_flags),
		.eps_in        (pw_eps),
		.u3            (pw_u3),
		.u6            (pw_u6),
		.v3            (pw_v3),
		.v6            (pw_v6),
		.valid         (out_valid),
		.energy        (energy),
		.inside_cutoff (inside_cutoff),
		.saturated     (saturated)
	);

	// Saturation only happens for pairs inside the cutoff.
	`LJPE_ASSERT_NEVER(a_sat_outside, clk, arst_n, out_valid && saturated && !inside_cutoff)
	// Pairs outside the cutoff and load beats give zero energy.
	`LJPE_ASSERT(a_outside_zero, clk, arst_n, out_valid && !inside_cutoff |-> energy == '0)
	// A clipped energy sits on one of the two rails.
	`LJPE_ASSERT(a_sat_rail, clk, arst_n, out_valid && saturated |-> energy == ljpe_pkg::ENERGY_POS_MAX || energy == ljpe_pkg::ENERGY_NEG_MIN)

endmodule

// ----- dv/lj_pair_energy_min_image_core_tb.sv -----
// Self-checking testbench for the Lennard-Jones pair energy core with minimum image.
`timescale 1ns / 1ps
module lj_pair_energy_min_image_core_tb;

	typedef logic [127:0] u128_t;

	typedef struct {
		logic        op;
		logic [31:0] ax, ay, az, bx, by, bz;
		logic [3:0]  sa, sb;
		logic [31:0] eps, sg, rc;
		bit          typed;
		logic [63:0] x_energy;
		logic        x_inside, x_sat;
	} pair_beat_t;

	typedef struct {
		logic [63:0] energy;
		logic        in_cut;
		logic        sat;
	} energy_res_t;

	logic clk, arst_n;
	logic in_valid, in_stall, operation;
	logic [31:0] pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z;
	logic [3:0] species_a, species_b;
	logic [31:0] load_epsilon, load_sigma, load_cutoff;
	logic out_valid, out_stall;
	logic signed [63:0] energy;
	logic inside_cutoff, saturated;
	logic cfg_we;
	logic [ljpe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;

	// predictor state
	logic [31:0] box_len [3];
	logic [31:0] eps_tab [256];
	logic [31:0] sig_tab [256];
	logic [31:0] cut_tab [256];
	bit          loaded [256];
	int          loaded_idx [$];

	energy_res_t energy_q [$];
	int errors = 0;
	int n_results = 0;
	int n_sat = 0;
	int n_inside = 0;
	int n_beats = 0;
	int stall_mode = 0;

	lj_pair_energy_min_image_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", energy_q.size());
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] axis_sep(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] box);
		logic [63:0] d;
		d = (a > b) ? a - b : b - a;
		if (2 * d > box)
			d = (d > box) ? d - box : box - d;
		return d;
	endfunction

	function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b,
			inout logic ovf);
		u128_t p;
		p = ({64'b0, a} * {64'b0, b}) >> 32;
		if (p[127:64] != 0) begin
			ovf = 1'b1;
			return '1;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] q32_ratio(input logic [63:0] s2, input u128_t den,
			inout logic ovf);
		u128_t q;
		q = {32'b0, s2, 32'b0} / den;
		if (q[127:64] != 0) begin
			ovf = 1'b1;
			return '1;
		end
		return q[63:0];
	endfunction

	// Shifted 12-6 energy of one beat against the current table and box.
	function automatic energy_res_t predict_energy(input pair_beat_t b);
		energy_res_t r;
		logic [63:0] dx, dy, dz, s2, rcs, u, u3, u6, v, v3, v6, eps;
		u128_t rs, pos, neg, mag, e;
		logic ovf, negative;
		int idx;
		r = '{64'd0, 1'b0, 1'b0};
		idx = b.sa * ljpe_pkg::NUM_SPECIES + b.sb;
		if (b.op == ljpe_pkg::OP_LOAD)
			return r;
		dx = axis_sep(b.ax, b.bx, box_len[0]);
		dy = axis_sep(b.ay, b.by, box_len[1]);
		dz = axis_sep(b.az, b.bz, box_len[2]);
		rs = u128_t'(dx) * dx + u128_t'(dy) * dy + u128_t'(dz) * dz;
		rcs = 64'(cut_tab[idx]) * cut_tab[idx];
		if (rs >= u128_t'(rcs))
			return r;
		r.in_cut = 1'b1;
		if (rs == 0) begin
			r.energy = ljpe_pkg::ENERGY_POS_MAX;
			r.sat = 1'b1;
			return r;
		end
		ovf = 1'b0;
		s2 = 64'(sig_tab[idx]) * sig_tab[idx];
		u = q32_ratio(s2, rs, ovf);
		u3 = q32_mul(q32_mul(u, u, ovf), u, ovf);
		u6 = q32_mul(u3, u3, ovf);
		v = q32_ratio(s2, u128_t'(rcs), ovf);
		v3 = q32_mul(q32_mul(v, v, ovf), v, ovf);
		v6 = q32_mul(v3, v3, ovf);
		if (ovf) begin
			r.energy = ljpe_pkg::ENERGY_POS_MAX;
			r.sat = 1'b1;
			return r;
		end
		pos = u128_t'(u6) + v3;
		neg = u128_t'(u3) + v6;
		negative = pos < neg;
		mag = negative ? neg - pos : pos - neg;
		eps = 64'(eps_tab[idx]);
		e = (mag * eps) >> ljpe_pkg::E_SHIFT;
		if (!negative) begin
			if (e > u128_t'(ljpe_pkg::ENERGY_POS_MAX)) begin
				r.energy = ljpe_pkg::ENERGY_POS_MAX;
				r.sat = 1'b1;
			end else
				r.energy = e[63:0];
		end else begin
			if (e > u128_t'(ljpe_pkg::ENERGY_NEG_MIN)) begin
				r.energy = ljpe_pkg::ENERGY_NEG_MIN;
				r.sat = 1'b1;
			end else
				r.energy = 64'd0 - e[63:0];
		end
		return r;
	endfunction

	// Present one beat, hold it until accepted, then log its expected result.
	task automatic send_beat(input pair_beat_t b);
		energy_res_t r;
		int idx;
		in_valid <= 1'b1;
		operation <= b.op;
		pos_a_x <= b.ax;
		pos_a_y <= b.ay;
		pos_a_z <= b.az;
		pos_b_x <= b.bx;
		pos_b_y <= b.by;
		pos_b_z <= b.bz;
		species_a <= b.sa;
		species_b <= b.sb;
		load_epsilon <= b.eps;
		load_sigma <= b.sg;
		load_cutoff <= b.rc;
		do @(posedge clk); while (in_stall);
		r = predict_energy(b);
		if (b.typed && (r.energy !== b.x_energy || r.in_cut !== b.x_inside
				|| r.sat !== b.x_sat))
			$display("%0t: table row disagrees with prediction", $time);
		if (b.typed)
			r = '{b.x_energy, b.x_inside, b.x_sat};
		idx = b.sa * ljpe_pkg::NUM_SPECIES + b.sb;
		if (b.op == ljpe_pkg::OP_LOAD) begin
			eps_tab[idx] = b.eps;
			sig_tab[idx] = b.sg;
			cut_tab[idx] = b.rc;
			if (!loaded[idx]) begin
				loaded[idx] = 1'b1;
				loaded_idx.push_back(idx);
			end
		end
		energy_q.push_back(r);
		n_beats++;
	endtask

	// Sender idles in bursts: sometimes drop valid for a short random gap.
	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every beat in flight has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (energy_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_box(input logic [ljpe_pkg::CFG_IDX_W-1:0] which,
			input logic [31:0] len);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		box_len[which] = len;
	endtask

	function automatic pair_beat_t load_row(input logic [3:0] sa, input logic [3:0] sb,
			input logic [31:0] eps, input logic [31:0] sg, input logic [31:0] rc);
		pair_beat_t b;
		b = '{ljpe_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, sa, sb, eps, sg, rc, 1'b1, 64'd0,
			1'b0, 1'b0};
		return b;
	endfunction

	function automatic pair_beat_t pair_row(input logic [3:0] sa, input logic [3:0] sb,
			input logic [31:0] ax, input logic [31:0] bx, input logic [31:0] by,
			input bit typed, input logic [63:0] xe, input logic xi, input logic xs);
		pair_beat_t b;
		b = '{ljpe_pkg::OP_COMPUTE, ax, 32'h0100_0000, 32'h0100_0000, bx, by,
			32'h0100_0000, sa, sb, 32'd0, 32'd0, 32'd0, typed, xe, xi, xs};
		return b;
	endfunction

	// Random beat: mostly near pairs on loaded entries, some loads and far pairs.
	function automatic pair_beat_t rand_beat();
		pair_beat_t b;
		int idx, mode;
		logic [31:0] d [3];
		mode = $urandom_range(0, 99);
		b.typed = 1'b0;
		b.x_energy = '0;
		b.x_inside = 1'b0;
		b.x_sat = 1'b0;
		b.ax = $urandom;
		b.ay = $urandom;
		b.az = $urandom;
		b.bx = $urandom;
		b.by = $urandom;
		b.bz = $urandom;
		b.eps = $urandom;
		b.sg = $urandom;
		b.rc = $urandom;
		if (mode < 12) begin
			b.op = ljpe_pkg::OP_LOAD;
			idx = $urandom_range(0, 255);
			if ($urandom_range(0, 3) != 0) begin
				b.eps = $urandom_range(32'h0001_0000, 32'h0040_0000);
				b.sg = $urandom_range(32'h0008_0000, 32'h0020_0000);
				b.rc = b.sg * $urandom_range(2, 4) + $urandom_range(0, 32'h000F_FFFF);
			end
		end else begin
			b.op = ljpe_pkg::OP_COMPUTE;
			idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
			foreach (d[i])
				d[i] = $urandom_range(0, 32'h0040_0000);
			b.bx = $urandom_range(0, 1) ? b.ax + d[0] : b.ax - d[0];
			b.by = $urandom_range(0, 1) ? b.ay + d[1] : b.ay - d[1];
			b.bz = $urandom_range(0, 1) ? b.az + d[2] : b.az - d[2];
			if (mode >= 85) begin
				b.bx = $urandom;
				b.by = $urandom;
				b.bz = $urandom;
			end
		end
		b.sa = 4'(idx / ljpe_pkg::NUM_SPECIES);
		b.sb = 4'(idx % ljpe_pkg::NUM_SPECIES);
		return b;
	endfunction

	// Receiver stall pattern: switch between no, light and heavy stall.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		unique case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		energy_res_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (energy_q.size() == 0) begin
				$display("%0t: result with none expected: energy %h", $time, energy);
				errors++;
			end else begin
				x = energy_q.pop_front();
				n_results++;
				n_sat += saturated;
				n_inside += inside_cutoff;
				if (energy !== x.energy) begin
					$display("%0t: energy expected %h actual %h", $time, x.energy, energy);
					errors++;
				end
				if (inside_cutoff !== x.in_cut) begin
					$display("%0t: inside_cutoff expected %b actual %b", $time, x.in_cut,
						inside_cutoff);
					errors++;
				end
				if (saturated !== x.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, x.sat, saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		pair_beat_t dir [$];
		logic [31:0] boxes [3][3];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= ljpe_pkg::OP_COMPUTE;
		pos_a_x <= '0;
		pos_a_y <= '0;
		pos_a_z <= '0;
		pos_b_x <= '0;
		pos_b_y <= '0;
		pos_b_z <= '0;
		species_a <= '0;
		species_b <= '0;
		load_epsilon <= '0;
		load_sigma <= '0;
		load_cutoff <= '0;
		cfg_we <= 1'b0;
		cfg_index <= ljpe_pkg::CFG_BOX_X;
		cfg_wdata <= '0;
		foreach (box_len[i])
			box_len[i] = ljpe_pkg::BOX_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset box of 1024.0
		dir.push_back(load_row(0, 0, 32'h0010_0000, 32'h0010_0000, 32'h0028_0000));
		dir.push_back(load_row(15, 15, 32'hFFFF_FFFF, 32'h0010_0000, 32'hFFFF_FFFF));
		dir.push_back(load_row(3, 7, 32'h0010_0000, 32'h0020_0000, 32'h0060_0000));
		dir.push_back(load_row(15, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
		dir.push_back(pair_row(0, 0, 32'h1000_0000, 32'h1000_0000, 32'h0100_0000,
			1'b1, ljpe_pkg::ENERGY_POS_MAX, 1'b1, 1'b1));
		dir.push_back(pair_row(0, 0, 32'h1000_0000, 32'h1011_EB85, 32'h0100_0000,
			1'b0, 0, 0, 0));
		dir.push_back(pair_row(0, 0, 32'h1000_0000, 32'h1030_0000, 32'h0100_0000,
			1'b1, 64'd0, 1'b0, 1'b0));
		// wrap across the box: 1023.0 apart is 1.0 apart
		dir.push_back(pair_row(0, 0, 32'h0000_0000, 32'h3FF0_0000, 32'h0100_0000,
			1'b0, 0, 0, 0));
		dir.push_back(pair_row(0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 64'd0, 1'b0, 1'b0));
		// tiny separation: the powers of the ratio overflow
		dir.push_back(pair_row(15, 15, 32'h2000_0000, 32'h2000_0100, 32'h0100_0000,
			1'b1, ljpe_pkg::ENERGY_POS_MAX, 1'b1, 1'b1));
		dir.push_back(pair_row(15, 15, 32'h2000_0000, 32'h200E_6666, 32'h0100_0000,
			1'b0, 0, 0, 0));
		dir.push_back(pair_row(3, 7, 32'h0000_0000, 32'h0020_0000, 32'h0100_0000,
			1'b0, 0, 0, 0));
		dir.push_back(pair_row(3, 7, 32'h0000_0000, 32'h0024_CCCC, 32'h0100_0000,
			1'b0, 0, 0, 0));
		dir.push_back(pair_row(15, 0, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000,
			1'b1, ljpe_pkg::ENERGY_POS_MAX, 1'b1, 1'b1));
		dir.push_back(load_row(0, 0, 32'h0000_0000, 32'h0010_0000, 32'h0028_0000));
		dir.push_back(pair_row(0, 0, 32'h1000_0000, 32'h1010_0000, 32'h0100_0000,
			1'b0, 0, 0, 0));
		foreach (dir[i]) begin
			send_beat(dir[i]);
			sender_gap();
		end

		boxes = '{'{32'h0800_0000, 32'h0400_0000, 32'h0200_0000},
			'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001},
			'{$urandom, $urandom, $urandom}};
		// random phases: reset box first, then each box setting
		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0) begin
				drain();
				write_box(ljpe_pkg::CFG_BOX_X, boxes[ph-1][0]);
				write_box(ljpe_pkg::CFG_BOX_Y, boxes[ph-1][1]);
				write_box(ljpe_pkg::CFG_BOX_Z, boxes[ph-1][2]);
			end
			repeat (170) begin
				send_beat(rand_beat());
				sender_gap();
			end
		end
		in_valid <= 1'b0;
		while (energy_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		$display("sent %0d beats over four box settings; %0d results checked", n_beats,
			n_results);
		$display("%0d pairs inside cutoff, %0d saturated", n_inside, n_sat);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
